// File: hdl/htfr_pkg.sv
// Shared constants and types for the header/trailer frame receiver.
// Used by header_trailer_frame_receiver; depends on nothing else.
package htfr_pkg;

   // Size of the external frame buffer, in bytes.
   localparam int BufferDepth = 16384;
   localparam int FillWidth   = $clog2(BufferDepth);

   localparam int ByteWidth    = 8;
   localparam int RunWidth     = 4;
   localparam int IndexWidth   = 14;
   localparam int LengthWidth  = 15;
   localparam int CountWidth   = 16;
   localparam int CsrIdxWidth  = 2;

   localparam logic [ByteWidth-1:0] FirstHeaderReset  = 8'h53;
   localparam logic [ByteWidth-1:0] SecondHeaderReset = 8'h41;
   localparam logic [ByteWidth-1:0] EndByteReset      = 8'h45;
   localparam logic [RunWidth-1:0]  EndRunReset       = 4'd8;

   typedef enum logic [1:0] {
      StatDiscard  = 2'd0,
      StatStored   = 2'd1,
      StatComplete = 2'd2,
      StatOverflow = 2'd3
   } status_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CsrFirstHeader  = 2'd0,
      CsrSecondHeader = 2'd1,
      CsrEndByte      = 2'd2,
      CsrEndRun       = 2'd3
   } csr_index_type;

endpackage

// File: hdl/header_trailer_frame_receiver.sv
// Header/trailer frame receiver: one result word for each received byte.
// Depends on htfr_pkg for constants and the status and register codes.

// The block takes one received byte per word on the req_ channel and returns one
// result word on the rsp_ channel: discarded, stored at rsp_write_index, stored
// and frame complete (with rsp_frame_length), or overflow with the frame dropped.
// A frame opens with the first and second header bytes and closes after a run of
// end_run_length consecutive end bytes; a run length of zero acts as one. The
// buffer itself is external: write rsp_data_byte at rsp_write_index when the
// status says stored or complete. The frame state and the result register are
// updated in the cycle the byte is accepted, and a new byte is taken every cycle
// while the result register is empty or being read. Registers are written through
// the csr_ port (always ready); the user must write them only while no byte is in
// flight, as the block does not enforce it. Reset brings the registers to 'S', 'A', 'E' and 8.
module header_trailer_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [htfr_pkg::ByteWidth-1:0]       req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [htfr_pkg::IndexWidth-1:0]      rsp_write_index,
   output logic [htfr_pkg::ByteWidth-1:0]       rsp_data_byte,
   output logic [htfr_pkg::LengthWidth-1:0]     rsp_frame_length,
   output logic [htfr_pkg::CountWidth-1:0]      rsp_frames_received,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [htfr_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [htfr_pkg::ByteWidth-1:0]       csr_wdata
);

   logic [htfr_pkg::ByteWidth-1:0]   first_hdr_ff,  first_hdr_in;
   logic [htfr_pkg::ByteWidth-1:0]   second_hdr_ff, second_hdr_in;
   logic [htfr_pkg::ByteWidth-1:0]   end_byte_ff,   end_byte_in;
   logic [htfr_pkg::RunWidth-1:0]    end_run_ff,    end_run_in;

   logic [htfr_pkg::FillWidth-1:0]   fill_ff,       fill_in;
   logic                             in_trailer_ff, in_trailer_in;
   logic [htfr_pkg::RunWidth-1:0]    run_count_ff,  run_count_in;
   logic [htfr_pkg::CountWidth-1:0]  frame_cnt_ff,  frame_cnt_in;

   logic                             rsp_valid_ff,  rsp_valid_in;
   htfr_pkg::status_type             status_ff,     status_in;
   logic [htfr_pkg::IndexWidth-1:0]  index_ff,      index_in;
   logic [htfr_pkg::ByteWidth-1:0]   data_ff,       data_in;
   logic [htfr_pkg::LengthWidth-1:0] length_ff,     length_in;
   logic [htfr_pkg::CountWidth-1:0]  count_out_ff,  count_out_in;

   logic                             req_take;
   logic                             in_body;
   logic [htfr_pkg::RunWidth-1:0]    run_need;
   logic [htfr_pkg::RunWidth:0]      run_next;
   logic                             run_done;
   logic                             buffer_full;
   logic [htfr_pkg::FillWidth:0]     fill_plus_one;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_write_index     = index_ff;
   assign rsp_data_byte       = data_ff;
   assign rsp_frame_length    = length_ff;
   assign rsp_frames_received = count_out_ff;

   // Register writes.
   always_comb begin
      first_hdr_in  = first_hdr_ff;
      second_hdr_in = second_hdr_ff;
      end_byte_in   = end_byte_ff;
      end_run_in    = end_run_ff;
      if (csr_valid) begin
         case (htfr_pkg::csr_index_type'(csr_index))
            htfr_pkg::CsrFirstHeader:  first_hdr_in  = csr_wdata;
            htfr_pkg::CsrSecondHeader: second_hdr_in = csr_wdata;
            htfr_pkg::CsrEndByte:      end_byte_in   = csr_wdata;
            htfr_pkg::CsrEndRun:       end_run_in    = csr_wdata[htfr_pkg::RunWidth-1:0];
            default: ;
         endcase
      end
   end

   assign in_body       = in_trailer_ff || (fill_ff >= htfr_pkg::FillWidth'(2));
   assign run_need      = (end_run_ff == '0) ? htfr_pkg::RunWidth'(1) : end_run_ff;
   assign run_next      = {1'b0, run_count_ff} + (htfr_pkg::RunWidth+1)'(1);
   assign run_done      = (req_rx_byte == end_byte_ff) && (run_next >= {1'b0, run_need});
   assign buffer_full   = fill_ff >= htfr_pkg::FillWidth'(htfr_pkg::BufferDepth - 1);
   assign fill_plus_one = {1'b0, fill_ff} + (htfr_pkg::FillWidth+1)'(1);

   // Frame state and the result word for the byte at the port.
   always_comb begin
      fill_in       = fill_ff;
      in_trailer_in = in_trailer_ff;
      run_count_in  = run_count_ff;
      frame_cnt_in  = frame_cnt_ff;
      status_in     = htfr_pkg::StatDiscard;
      index_in      = '0;
      data_in       = '0;
      length_in     = '0;

      if (in_body) begin
         if (req_rx_byte == end_byte_ff) begin
            run_count_in  = run_next[htfr_pkg::RunWidth-1:0];
            in_trailer_in = 1'b1;
         end else begin
            run_count_in  = '0;
            in_trailer_in = 1'b0;
         end
         if (run_done) begin
            status_in     = htfr_pkg::StatComplete;
            index_in      = htfr_pkg::IndexWidth'(fill_ff);
            data_in       = req_rx_byte;
            length_in     = htfr_pkg::LengthWidth'(fill_plus_one);
            frame_cnt_in  = frame_cnt_ff + htfr_pkg::CountWidth'(1);
            fill_in       = '0;
            in_trailer_in = 1'b0;
            run_count_in  = '0;
         end else if (buffer_full) begin
            status_in     = htfr_pkg::StatOverflow;
            fill_in       = '0;
            in_trailer_in = 1'b0;
            run_count_in  = '0;
         end else begin
            status_in = htfr_pkg::StatStored;
            index_in  = htfr_pkg::IndexWidth'(fill_ff);
            data_in   = req_rx_byte;
            fill_in   = fill_plus_one[htfr_pkg::FillWidth-1:0];
         end
      end else if ((fill_ff == htfr_pkg::FillWidth'(1)) && (req_rx_byte == second_hdr_ff)) begin
         status_in = htfr_pkg::StatStored;
         index_in  = htfr_pkg::IndexWidth'(1);
         data_in   = req_rx_byte;
         fill_in   = htfr_pkg::FillWidth'(2);
      end else if (req_rx_byte == first_hdr_ff) begin
         // Unless taken as the second header, a first header byte restarts the frame.
         status_in     = htfr_pkg::StatStored;
         data_in       = req_rx_byte;
         fill_in       = htfr_pkg::FillWidth'(1);
         in_trailer_in = 1'b0;
         run_count_in  = '0;
      end else begin
         fill_in       = '0;
         in_trailer_in = 1'b0;
         run_count_in  = '0;
      end
      count_out_in = frame_cnt_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_hdr_ff  <= htfr_pkg::FirstHeaderReset;
         second_hdr_ff <= htfr_pkg::SecondHeaderReset;
         end_byte_ff   <= htfr_pkg::EndByteReset;
         end_run_ff    <= htfr_pkg::EndRunReset;
         fill_ff       <= '0;
         in_trailer_ff <= 1'b0;
         run_count_ff  <= '0;
         frame_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_hdr_ff  <= first_hdr_in;
         second_hdr_ff <= second_hdr_in;
         end_byte_ff   <= end_byte_in;
         end_run_ff    <= end_run_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_take) begin
            fill_ff       <= fill_in;
            in_trailer_ff <= in_trailer_in;
            run_count_ff  <= run_count_in;
            frame_cnt_ff  <= frame_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         status_ff    <= status_in;
         index_ff     <= index_in;
         data_ff      <= data_in;
         length_ff    <= length_in;
         count_out_ff <= count_out_in;
      end
   end

`ifndef SYNTH
   // A pending end-byte run only exists inside the trailer.
   assert property (@(posedge clock) disable iff (reset)
      (run_count_ff != '0) |-> in_trailer_ff)
      else $error("end run count set outside the trailer");

   // The trailer is only reached after both header bytes were stored.
   assert property (@(posedge clock) disable iff (reset)
      in_trailer_ff |-> (fill_ff >= htfr_pkg::FillWidth'(2)))
      else $error("trailer state with an incomplete header");

   // Discarded and dropped words carry no buffer write.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((status_ff == htfr_pkg::StatDiscard) ||
                        (status_ff == htfr_pkg::StatOverflow)))
      |-> ((index_ff == '0) && (data_ff == '0) && (length_ff == '0)))
      else $error("write fields set on a discarded or dropped word");

   // A completed frame ends at the byte written last.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == htfr_pkg::StatComplete))
      |-> (length_ff[htfr_pkg::IndexWidth-1:0] == index_ff + htfr_pkg::IndexWidth'(1)))
      else $error("frame length does not match the last write index");

   // The frame counter holds on every accepted byte that does not complete a frame.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (status_in != htfr_pkg::StatComplete))
      |=> (frame_cnt_ff == $past(frame_cnt_ff)))
      else $error("frame counter changed without a completed frame");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking bench for header_trailer_frame_receiver: drives received bytes and
// register writes, predicts each result word and compares it field by field.
// Depends on htfr_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

   localparam int ClockHalf     = 6;
   localparam int CycleLimit    = 1000000;
   localparam int CalmStart     = 1500;
   localparam int CalmEnd       = 2000;
   localparam int SqueezeAfter  = 600;
   localparam int SqueezeCycles = 400;
   localparam int PhaseBytes    = 170;
   localparam int MaxReports    = 10;

   typedef struct packed {
      htfr_pkg::status_type                 status;
      logic [htfr_pkg::IndexWidth-1:0]      wr_index;
      logic [htfr_pkg::ByteWidth-1:0]       wr_data;
      logic [htfr_pkg::LengthWidth-1:0]     frame_len;
      logic [htfr_pkg::CountWidth-1:0]      frame_count;
   } rx_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [htfr_pkg::ByteWidth-1:0]      req_rx_byte = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [1:0]                          rsp_status;
   logic [htfr_pkg::IndexWidth-1:0]     rsp_write_index;
   logic [htfr_pkg::ByteWidth-1:0]      rsp_data_byte;
   logic [htfr_pkg::LengthWidth-1:0]    rsp_frame_length;
   logic [htfr_pkg::CountWidth-1:0]     rsp_frames_received;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [htfr_pkg::CsrIdxWidth-1:0]    csr_index = '0;
   logic [htfr_pkg::ByteWidth-1:0]      csr_wdata = '0;

   header_trailer_frame_receiver DUT (.*);

   // Predicted register contents and frame state.
   logic [htfr_pkg::ByteWidth-1:0]  cfg_first  = htfr_pkg::FirstHeaderReset;
   logic [htfr_pkg::ByteWidth-1:0]  cfg_second = htfr_pkg::SecondHeaderReset;
   logic [htfr_pkg::ByteWidth-1:0]  cfg_end    = htfr_pkg::EndByteReset;
   logic [htfr_pkg::RunWidth-1:0]   cfg_run    = htfr_pkg::EndRunReset;
   int unsigned                     fill_pos = 0;
   bit                              trailer_active = 1'b0;
   int unsigned                     end_run = 0;
   logic [htfr_pkg::CountWidth-1:0] frames_done = '0;

   logic [htfr_pkg::ByteWidth-1:0]  pending_bytes [$];
   rx_result_type                   frame_results_due [$];

   int unsigned cycle_count = 0;
   int unsigned bytes_accepted = 0;
   int unsigned mismatches = 0;
   bit          req_fire = 1'b0;
   bit          csr_fire = 1'b0;
   int          stall_left = 0;
   bit          squeezed = 1'b0;

   initial forever #ClockHalf clock = ~clock;

   function automatic bit take_break();
      if (cycle_count >= CalmStart && cycle_count < CalmEnd) return 1'b0;
      return $urandom_range(0, 99) < 23;
   endfunction

   function automatic void clear_frame();
      fill_pos = 0;
      trailer_active = 1'b0;
      end_run = 0;
   endfunction

   function automatic rx_result_type track_frame_byte(
      input logic [htfr_pkg::ByteWidth-1:0] b);
      rx_result_type r;
      bit closes;
      int unsigned need;
      r = '0;
      r.status = htfr_pkg::StatDiscard;
      closes = 1'b0;
      need = (cfg_run == 0) ? 1 : cfg_run;
      if (trailer_active || fill_pos >= 2) begin
         if (b == cfg_end) begin
            if (end_run + 1 >= need) begin
               closes = 1'b1;
            end else begin
               end_run++;
               trailer_active = 1'b1;
            end
         end else begin
            end_run = 0;
            trailer_active = 1'b0;
         end
         if (closes) begin
            r.status = htfr_pkg::StatComplete;
            r.wr_index = htfr_pkg::IndexWidth'(fill_pos);
            r.wr_data = b;
            r.frame_len = htfr_pkg::LengthWidth'(fill_pos + 1);
            frames_done = frames_done + 1'b1;
            clear_frame();
         end else if (fill_pos >= htfr_pkg::BufferDepth - 1) begin
            // The buffer is full and the frame is not closing: drop all of it.
            r.status = htfr_pkg::StatOverflow;
            clear_frame();
         end else begin
            r.status = htfr_pkg::StatStored;
            r.wr_index = htfr_pkg::IndexWidth'(fill_pos);
            r.wr_data = b;
            fill_pos++;
         end
      end else if (fill_pos == 0 && b == cfg_first) begin
         r.status = htfr_pkg::StatStored;
         r.wr_data = b;
         fill_pos = 1;
      end else if (fill_pos == 1 && b == cfg_second) begin
         r.status = htfr_pkg::StatStored;
         r.wr_index = htfr_pkg::IndexWidth'(1);
         r.wr_data = b;
         fill_pos = 2;
      end else begin
         // A bad header byte drops the partial frame; a fresh opening byte restarts.
         clear_frame();
         if (b == cfg_first) begin
            r.status = htfr_pkg::StatStored;
            r.wr_data = b;
            fill_pos = 1;
         end
      end
      r.frame_count = frames_done;
      return r;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("%s", msg);
   endfunction

   // Sampling side: register writes, accepted bytes and returned result words.
   always @(posedge clock) begin
      rx_result_type want;
      string got_text;
      cycle_count <= cycle_count + 1;
      req_fire <= !reset && req_valid && req_ready;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               htfr_pkg::CsrFirstHeader:  cfg_first = csr_wdata;
               htfr_pkg::CsrSecondHeader: cfg_second = csr_wdata;
               htfr_pkg::CsrEndByte:      cfg_end = csr_wdata;
               htfr_pkg::CsrEndRun:       cfg_run = csr_wdata[htfr_pkg::RunWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            frame_results_due.push_back(track_frame_byte(req_rx_byte));
            bytes_accepted <= bytes_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_results_due.size() == 0) begin
               note_mismatch($sformatf("unexpected word: status %0d index %0d data %02h",
                  rsp_status, rsp_write_index, rsp_data_byte));
            end else begin
               want = frame_results_due.pop_front();
               if (rsp_status !== want.status || rsp_write_index !== want.wr_index ||
                   rsp_data_byte !== want.wr_data || rsp_frame_length !== want.frame_len ||
                   rsp_frames_received !== want.frame_count) begin
                  got_text = $sformatf("st %0d idx %0d data %02h len %0d cnt %0d",
                     rsp_status, rsp_write_index, rsp_data_byte,
                     rsp_frame_length, rsp_frames_received);
                  note_mismatch($sformatf(
                     "mismatch: expected st %0d idx %0d data %02h len %0d cnt %0d, got %s",
                     want.status, want.wr_index, want.wr_data, want.frame_len,
                     want.frame_count, got_text));
               end
            end
         end
      end
   end

   // Byte sender.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_bytes.size() != 0 && !take_break()) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver, with one long hold-off so that the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!squeezed && bytes_accepted >= SqueezeAfter) begin
         squeezed <= 1'b1;
         stall_left <= SqueezeCycles;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_break();
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || frame_results_due.size() != 0);
      @(negedge clock);
   endtask

   // Called at a falling edge; writes all four registers in index order.
   task automatic program_registers(
      input logic [htfr_pkg::ByteWidth-1:0] first_b, second_b, end_b,
      input logic [htfr_pkg::RunWidth-1:0] run);
      htfr_pkg::csr_index_type regs [4];
      logic [htfr_pkg::ByteWidth-1:0] vals [4];
      regs = '{htfr_pkg::CsrFirstHeader, htfr_pkg::CsrSecondHeader,
               htfr_pkg::CsrEndByte, htfr_pkg::CsrEndRun};
      vals = '{first_b, second_b, end_b, {4'($urandom), run}};
      foreach (regs[i]) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         do @(negedge clock);
         while (!csr_fire);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic queue_frame(input logic [htfr_pkg::ByteWidth-1:0] first_b, second_b, end_b,
                              input int unsigned need);
      int unsigned body_len;
      logic [htfr_pkg::ByteWidth-1:0] b;
      pending_bytes.push_back(first_b);
      pending_bytes.push_back(second_b);
      body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
      repeat (body_len) begin
         case ($urandom_range(0, 9))
            0:       b = end_b;
            1:       b = first_b;
            2:       b = second_b;
            default: b = 8'($urandom);
         endcase
         pending_bytes.push_back(b);
      end
      // Sometimes the trailer breaks off, so the run of end bytes has to restart.
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(0, need - 1)) pending_bytes.push_back(end_b);
         pending_bytes.push_back(end_b ^ 8'($urandom_range(1, 255)));
      end
      repeat (need) pending_bytes.push_back(end_b);
   endtask

   task automatic queue_sequence(
      input logic [htfr_pkg::ByteWidth-1:0] first_b, second_b, end_b,
      input logic [htfr_pkg::RunWidth-1:0] run);
      int unsigned kind;
      int unsigned need;
      kind = $urandom_range(0, 99);
      need = (run == 0) ? 1 : run;
      if (kind < 70) begin
         queue_frame(first_b, second_b, end_b, need);
      end else if (kind < 80) begin
         pending_bytes.push_back(first_b);
         pending_bytes.push_back(8'($urandom));
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 3)) pending_bytes.push_back(first_b);
         queue_frame(first_b, second_b, end_b, need);
      end
   endtask

   task automatic run_phase(input logic [htfr_pkg::ByteWidth-1:0] first_b, second_b, end_b,
                            input logic [htfr_pkg::RunWidth-1:0] run);
      wait_drained();
      program_registers(first_b, second_b, end_b, run);
      @(posedge clock);
      while (pending_bytes.size() < PhaseBytes) queue_sequence(first_b, second_b, end_b, run);
   endtask

   // Frame with the reset header bytes, a body free of end bytes and a given trailer.
   task automatic queue_long_frame(input int unsigned body_len, input int unsigned end_count);
      pending_bytes.push_back(htfr_pkg::FirstHeaderReset);
      pending_bytes.push_back(htfr_pkg::SecondHeaderReset);
      repeat (body_len)
         pending_bytes.push_back(htfr_pkg::EndByteReset ^ 8'($urandom_range(1, 255)));
      repeat (end_count) pending_bytes.push_back(htfr_pkg::EndByteReset);
   endtask

   initial begin
      logic [htfr_pkg::ByteWidth-1:0] opening [24];
      opening = '{8'h00, 8'hFF, htfr_pkg::SecondHeaderReset,
                  htfr_pkg::FirstHeaderReset, htfr_pkg::FirstHeaderReset,
                  htfr_pkg::SecondHeaderReset,
                  8'h00, 8'hFF, htfr_pkg::FirstHeaderReset, htfr_pkg::SecondHeaderReset,
                  htfr_pkg::EndByteReset, htfr_pkg::EndByteReset, htfr_pkg::EndByteReset,
                  8'h12,
                  htfr_pkg::EndByteReset, htfr_pkg::EndByteReset, htfr_pkg::EndByteReset,
                  htfr_pkg::EndByteReset, htfr_pkg::EndByteReset, htfr_pkg::EndByteReset,
                  htfr_pkg::EndByteReset, htfr_pkg::EndByteReset,
                  htfr_pkg::FirstHeaderReset, 8'h00};
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening[i]) pending_bytes.push_back(opening[i]);

      run_phase(8'h00, 8'hFF, 8'hFF, 4'd1);
      run_phase(8'hFF, 8'h00, 8'h00, 4'd15);
      run_phase(8'h5A, 8'h5A, 8'h5A, 4'd3);
      run_phase(8'($urandom), 8'($urandom), 8'($urandom), 4'd0);
      run_phase(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
      run_phase(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
      run_phase(htfr_pkg::FirstHeaderReset, htfr_pkg::SecondHeaderReset,
                htfr_pkg::EndByteReset, htfr_pkg::EndRunReset);

      // Longer frames, run length three; two have too few end bytes and run on.
      wait_drained();
      program_registers(htfr_pkg::FirstHeaderReset, htfr_pkg::SecondHeaderReset,
                        htfr_pkg::EndByteReset, 4'd3);
      @(posedge clock);
      queue_long_frame(60, 3);
      queue_long_frame(30, 0);
      queue_long_frame(45, 2);
      queue_long_frame(5, 3);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && frame_results_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

endmodule
